// ----- rtl/mcsr_pkg.sv -----
// Package for the machine-mode CSR file: word types, CSR numbers, slot indexes,
// status and operation codes, and the address decoder and reset value functions.
// Depends on nothing.
package mcsr_pkg;

    // Operation codes carried in the op field of an input word.
    localparam logic [1:0] OP_READ       = 2'd0;
    localparam logic [1:0] OP_WRITE      = 2'd1;
    localparam logic [1:0] OP_TRAP_ENTER = 2'd2;
    localparam logic [1:0] OP_TRAP_EXIT  = 2'd3;

    // Status codes returned in each result word.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // Standard CSR numbers.
    localparam logic [11:0] A_MSTATUS   = 12'h300;
    localparam logic [11:0] A_MISA      = 12'h301;
    localparam logic [11:0] A_MIE       = 12'h304;
    localparam logic [11:0] A_MTVEC     = 12'h305;
    localparam logic [11:0] A_MSCRATCH  = 12'h340;
    localparam logic [11:0] A_MEPC      = 12'h341;
    localparam logic [11:0] A_MCAUSE    = 12'h342;
    localparam logic [11:0] A_MTVAL     = 12'h343;
    localparam logic [11:0] A_MIP       = 12'h344;
    localparam logic [11:0] A_MCYCLE    = 12'hB00;
    localparam logic [11:0] A_MINSTRET  = 12'hB02;
    localparam logic [11:0] A_MCYCLEH   = 12'hB80;
    localparam logic [11:0] A_MINSTRETH = 12'hB82;
    localparam logic [11:0] A_CYCLE     = 12'hC00;
    localparam logic [11:0] A_INSTRET   = 12'hC02;
    localparam logic [11:0] A_CYCLEH    = 12'hC80;
    localparam logic [11:0] A_INSTRETH  = 12'hC82;

    // Slots of the CSR memory. The two 64-bit counters occupy two slots each.
    localparam int unsigned CSR_DEPTH = 16;
    localparam int unsigned IDX_BITS  = 4;

    localparam logic [IDX_BITS-1:0] IDX_MSTATUS   = 4'd0;
    localparam logic [IDX_BITS-1:0] IDX_MISA      = 4'd1;
    localparam logic [IDX_BITS-1:0] IDX_MTVEC     = 4'd2;
    localparam logic [IDX_BITS-1:0] IDX_MIE       = 4'd3;
    localparam logic [IDX_BITS-1:0] IDX_MSCRATCH  = 4'd4;
    localparam logic [IDX_BITS-1:0] IDX_MEPC      = 4'd5;
    localparam logic [IDX_BITS-1:0] IDX_MCAUSE    = 4'd6;
    localparam logic [IDX_BITS-1:0] IDX_MTVAL     = 4'd7;
    localparam logic [IDX_BITS-1:0] IDX_MIP       = 4'd8;
    localparam logic [IDX_BITS-1:0] IDX_CYCLE_LO  = 4'd9;
    localparam logic [IDX_BITS-1:0] IDX_CYCLE_HI  = 4'd10;
    localparam logic [IDX_BITS-1:0] IDX_INSTR_LO  = 4'd11;
    localparam logic [IDX_BITS-1:0] IDX_INSTR_HI  = 4'd12;

    localparam logic [31:0] MIE_BIT  = 32'h0000_0008;
    localparam logic [31:0] INT_FLAG = 32'h8000_0000;

    localparam logic [31:0] RST_MSTATUS = 32'h0000_1800;
    localparam logic [31:0] RST_MISA    = 32'h4010_1105;
    localparam logic [31:0] RST_MTVEC   = 32'h4000_0000;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] csr_addr;
        logic [31:0] write_data;
        logic [31:0] trap_pc;
        logic [31:0] trap_cause;
        logic        trap_interrupt;
    } t_in_word;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
        logic [7:0]  trap_depth;
    } t_out_word;

    typedef struct packed {
        logic                known;
        logic                writable;
        logic [IDX_BITS-1:0] idx;
    } t_csr_dec;

    function automatic t_csr_dec csr_decode(input logic [11:0] addr);
        t_csr_dec d;
        d = '{known: 1'b1, writable: 1'b1, idx: IDX_MSTATUS};
        unique case (addr)
            A_MSTATUS:   d.idx = IDX_MSTATUS;
            A_MISA:      d.idx = IDX_MISA;
            A_MTVEC:     d.idx = IDX_MTVEC;
            A_MIE:       d.idx = IDX_MIE;
            A_MSCRATCH:  d.idx = IDX_MSCRATCH;
            A_MEPC:      d.idx = IDX_MEPC;
            A_MCAUSE:    d.idx = IDX_MCAUSE;
            A_MTVAL:     d.idx = IDX_MTVAL;
            A_MIP:       d.idx = IDX_MIP;
            A_MCYCLE:    d.idx = IDX_CYCLE_LO;
            A_MCYCLEH:   d.idx = IDX_CYCLE_HI;
            A_MINSTRET:  d.idx = IDX_INSTR_LO;
            A_MINSTRETH: d.idx = IDX_INSTR_HI;
            A_CYCLE: begin
                d.idx      = IDX_CYCLE_LO;
                d.writable = 1'b0;
            end
            A_CYCLEH: begin
                d.idx      = IDX_CYCLE_HI;
                d.writable = 1'b0;
            end
            A_INSTRET: begin
                d.idx      = IDX_INSTR_LO;
                d.writable = 1'b0;
            end
            A_INSTRETH: begin
                d.idx      = IDX_INSTR_HI;
                d.writable = 1'b0;
            end
            default: begin
                d.known    = 1'b0;
                d.writable = 1'b0;
            end
        endcase
        return d;
    endfunction

    // Value a slot holds until it is first written.
    function automatic logic [31:0] csr_reset(input logic [IDX_BITS-1:0] idx);
        logic [31:0] v;
        v = '0;
        case (idx)
            IDX_MSTATUS: v = RST_MSTATUS;
            IDX_MISA:    v = RST_MISA;
            IDX_MTVEC:   v = RST_MTVEC;
            default:     v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/machine_csr_file_with_trap_entry_top.sv -----
// Top level of the machine-mode CSR file with trap entry and exit.
// Depends on mcsr_pkg for word types, CSR numbers and the address decoder.

// All CSR state, including both halves of the cycle and instret counters,
// lives in one 16-entry synchronous memory with a registered read. A 16-bit
// valid vector, cleared by reset, makes an unwritten slot read as its reset
// value, so no clearing pass is needed after reset. Each accepted word reads
// one slot (the addressed CSR, or mstatus for trap words), then a small
// sequencer modifies and writes back through the single write port. A CSR
// read, a CSR write or a trap exit passes the execute and done steps before
// the next acceptance; a trap entry adds mepc, mcause and mtval steps, since
// it writes mstatus, mepc, mcause and mtval in turn on one port. The result
// sits in an output register, so the next word is accepted while a result
// still waits to be taken. Only one word is in flight at a time, so a read
// never overlaps a write to the same slot. The trap nesting level is a
// LEVEL_BITS-wide register that saturates at all ones and is reported in
// its low 8 bits. Unknown CSRs read as zero with an unknown status; writes
// to unknown CSRs or to the user counter aliases change nothing and are
// flagged as ignored.
module machine_csr_file_with_trap_entry_top #(
    parameter int unsigned LEVEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mcsr_pkg::t_in_word    i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mcsr_pkg::t_out_word   o_out_word
);
    import mcsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EPC,
        S_CAUSE,
        S_TVAL,
        S_DONE
    } t_state;

    t_state              r_state;
    t_in_word            r_item;
    t_csr_dec            r_dec;
    logic [IDX_BITS-1:0] r_ridx;
    t_out_word           r_res;
    t_out_word           r_out;
    logic                r_out_valid;
    logic [LEVEL_BITS-1:0] r_level;
    logic [LEVEL_BITS-1:0] n_level;

    // CSR memory with its per-slot valid bits.
    logic [31:0]         r_mem [CSR_DEPTH];
    logic [31:0]         r_rdata;
    logic                r_rvalid;
    logic [CSR_DEPTH-1:0] r_valid;

    t_csr_dec            w_in_dec;
    logic [IDX_BITS-1:0] w_raddr;
    logic                w_we;
    logic [IDX_BITS-1:0] w_waddr;
    logic [31:0]         w_wdata;
    logic [31:0]         w_cur;
    logic                w_accept;
    logic                w_out_take;
    t_out_word           w_res;

    // Widen and cut the level to the 8-bit depth field for any LEVEL_BITS.
    function automatic logic [7:0] depth8(input logic [LEVEL_BITS-1:0] lv);
        logic [39:0] wide;
        wide = 40'(lv);
        return wide[7:0];
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign w_out_take  = r_out_valid && !i_out_stall;

    // Trap words read mstatus; CSR words read the addressed slot.
    always_comb begin
        w_in_dec = csr_decode(i_in_word.csr_addr);
        if (i_in_word.op == OP_READ || i_in_word.op == OP_WRITE) begin
            w_raddr = w_in_dec.idx;
        end else begin
            w_raddr = IDX_MSTATUS;
        end
    end

    // Current value of the slot read for this word.
    assign w_cur = r_rvalid ? r_rdata : csr_reset(r_ridx);

    // Write port, result and next level for each sequencer step.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = IDX_MSTATUS;
        w_wdata = '0;
        n_level = r_level;
        w_res   = '{read_data: '0, status: ST_OK, trap_depth: depth8(r_level)};
        unique case (r_state)
            S_EXEC: begin
                case (r_item.op)
                    OP_READ: begin
                        if (r_dec.known) begin
                            w_res.read_data = w_cur;
                        end else begin
                            w_res.status = ST_UNKNOWN;
                        end
                    end
                    OP_WRITE: begin
                        if (r_dec.writable) begin
                            w_we    = 1'b1;
                            w_waddr = r_dec.idx;
                            w_wdata = r_item.write_data;
                        end else begin
                            w_res.status = ST_IGNORED;
                        end
                    end
                    OP_TRAP_ENTER: begin
                        w_we    = 1'b1;
                        w_waddr = IDX_MSTATUS;
                        w_wdata = w_cur & ~MIE_BIT;
                        if (!(&r_level)) begin
                            n_level = r_level + 1'b1;
                        end
                    end
                    default: begin
                        if (r_level != '0) begin
                            w_we    = 1'b1;
                            w_waddr = IDX_MSTATUS;
                            w_wdata = w_cur | MIE_BIT;
                            n_level = r_level - 1'b1;
                        end
                    end
                endcase
                w_res.trap_depth = depth8(n_level);
            end
            S_EPC: begin
                w_we    = 1'b1;
                w_waddr = IDX_MEPC;
                w_wdata = r_item.trap_pc;
            end
            S_CAUSE: begin
                w_we    = 1'b1;
                w_waddr = IDX_MCAUSE;
                w_wdata = r_item.trap_interrupt ? (r_item.trap_cause | INT_FLAG)
                                                : r_item.trap_cause;
            end
            S_TVAL: begin
                w_we    = 1'b1;
                w_waddr = IDX_MTVAL;
                w_wdata = r_item.write_data;
            end
            default: begin
            end
        endcase
    end

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata  <= r_mem[w_raddr];
        r_rvalid <= r_valid[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[w_waddr] <= 1'b1;
        end
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_level     <= '0;
        end else begin
            // In the done step the output register is reloaded below instead.
            if (w_out_take && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item  <= i_in_word;
                        r_dec   <= w_in_dec;
                        r_ridx  <= w_raddr;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_level <= n_level;
                    r_res   <= w_res;
                    r_state <= (r_item.op == OP_TRAP_ENTER) ? S_EPC : S_DONE;
                end
                S_EPC: begin
                    r_state <= S_CAUSE;
                end
                S_CAUSE: begin
                    r_state <= S_TVAL;
                end
                S_TVAL: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || w_out_take) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A trap entry always proceeds from the execute step to the mepc write.
    a_enter_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_item.op == OP_TRAP_ENTER) |=> (r_state == S_EPC))
        else $error("trap entry did not proceed to the mepc write");

    // The mepc write step is only reached from the execute step.
    a_epc_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EPC) |-> ($past(r_state) == S_EXEC))
        else $error("mepc write step entered out of order");

    // The nesting level changes only in the execute step.
    a_level_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_level != $past(r_level)) |-> ($past(r_state) == S_EXEC))
        else $error("nesting level changed outside the execute step");

endmodule
